// ===== rtl/core/hqp_pkg.sv =====
// types and constants shared by the quadratic-probe hash table
`default_nettype none
package hqp_pkg;

	localparam int KEY_W_MAX  = 64;
	localparam int SLOT_W_MAX = 12;
	localparam int VALUE_W    = 34;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_REMOVE = 2'd2
	} command_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_EXISTS    = 3'd1,
		ST_FULL      = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_REMOVED   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_DONE
	} back_state_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [47:0]        key_bytes;
		logic [2:0]         key_length;
		logic [VALUE_W-1:0] entry_value;
	} req_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [VALUE_W-1:0] found_value;
		logic [6:0]         probe_count;
	} rsp_word_t;

	// hashed request handed from front to back
	typedef struct packed {
		logic [1:0]            command;
		logic [KEY_W_MAX-1:0]  key;
		logic [2:0]            key_length;
		logic [VALUE_W-1:0]    entry_value;
		logic [SLOT_W_MAX-1:0] base;
	} job_t;

endpackage
`default_nettype wire

// ===== rtl/core/hqp_front.sv =====
// front end: takes requests, trims the key and hashes one character a cycle
`default_nettype none
module hqp_front #(
	parameter int TABLE_SLOTS = 101,
	parameter int KEY_CHARS   = 6
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	input  hqp_pkg::req_word_t req,
	output logic             job_valid,
	input  wire              job_full,
	output hqp_pkg::job_t    job
);
	import hqp_pkg::*;

	localparam int KW   = KEY_CHARS * 8;
	localparam int SW   = $clog2(TABLE_SLOTS);
	localparam int HW   = SW + 10;
	localparam int KMAX = (TABLE_SLOTS >= 7) ? 5 : 8;

	logic          busy_q;
	logic [2:0]    left_q;
	logic [1:0]    cmd_q;
	logic [2:0]    len_q;
	logic [VALUE_W-1:0] val_q;
	logic [KW-1:0] key_q;
	logic [KW-1:0] sh_q;
	logic [SW-1:0] h_q;

	logic [63:0]   ext;
	logic [KW-1:0] key_n;
	logic [2:0]    len_c;
	logic [HW-1:0] v;
	logic [HW-1:0] lim;
	logic [SW-1:0] h_nxt;
	logic          accept;
	logic          push;

	// clamp length and clear characters beyond it
	always_comb begin
		ext = {16'b0, req.key_bytes};
		len_c = ({1'b0, req.key_length} > 4'(KEY_CHARS)) ? 3'(KEY_CHARS) : req.key_length;
		key_n = ext[KW-1:0];
		for (int n = 0; n < KEY_CHARS; n++) begin
			if (4'(n) >= {1'b0, len_c})
				key_n[(KEY_CHARS-1-n)*8 +: 8] = 8'h00;
		end
	end

	// h*31 + c, then reduce by shifted copies of the slot count
	always_comb begin
		v = (HW'(h_q) << 5) - HW'(h_q) + HW'(sh_q[KW-1 -: 8]);
		for (int k = KMAX; k >= 0; k--) begin
			lim = HW'(TABLE_SLOTS) << k;
			if (v >= lim)
				v = v - lim;
		end
		h_nxt = v[SW-1:0];
	end

	assign req_stall = busy_q;
	assign accept    = req_valid && !busy_q;
	assign job_valid = busy_q && (left_q == 3'd0);
	assign push      = job_valid && !job_full;

	always_comb begin
		job.command     = cmd_q;
		job.key         = KEY_W_MAX'(key_q);
		job.key_length  = len_q;
		job.entry_value = val_q;
		job.base        = SLOT_W_MAX'(h_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= 3'd0;
		end else if (accept) begin
			busy_q <= 1'b1;
			left_q <= len_c;
		end else if (busy_q && left_q != 3'd0) begin
			left_q <= left_q - 3'd1;
		end else if (push) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			len_q <= len_c;
			val_q <= req.entry_value;
			key_q <= key_n;
			sh_q  <= key_n;
			h_q   <= '0;
		end else if (busy_q && left_q != 3'd0) begin
			h_q  <= h_nxt;
			sh_q <= sh_q << 8;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/hqp_queue.sv =====
// two-entry queue of hashed requests between front and back
`default_nettype none
module hqp_queue (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push_valid,
	output logic          full,
	input  hqp_pkg::job_t push_job,
	output logic          pop_valid,
	input  wire           pop,
	output hqp_pkg::job_t pop_job
);
	import hqp_pkg::*;

	job_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_job   = slot_q[rd_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_job;
	end

endmodule
`default_nettype wire

// ===== rtl/core/hqp_back.sv =====
// back end: probe walk over the slot memory and result register
`default_nettype none
module hqp_back #(
	parameter int TABLE_SLOTS = 101,
	parameter int KEY_CHARS   = 6
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               job_valid,
	output logic              job_pop,
	input  hqp_pkg::job_t     job,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output hqp_pkg::rsp_word_t rsp
);
	import hqp_pkg::*;

	localparam int KW    = KEY_CHARS * 8;
	localparam int SW    = $clog2(TABLE_SLOTS);
	localparam int CW    = $clog2(TABLE_SLOTS + 1);
	localparam int STEP0 = 2 % TABLE_SLOTS;

	typedef struct packed {
		logic               used;
		logic               deleted;
		logic [2:0]         klen;
		logic [KW-1:0]      key;
		logic [VALUE_W-1:0] value;
	} rec_t;

	rec_t mem [TABLE_SLOTS];

	back_state_t state_q, state_d;
	job_t          cur_q;
	rec_t          rd_q;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] step_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] clr_q;
	status_t       res_status_q;
	logic [VALUE_W-1:0] res_value_q;
	logic [CW-1:0] res_probes_q;
	logic          rsp_valid_q;
	rsp_word_t     rsp_q;

	logic          we;
	logic [SW-1:0] waddr;
	rec_t          wdata;
	logic          re;
	logic          load;
	logic          adv;
	logic          fin;
	status_t       fin_status;
	logic [VALUE_W-1:0] fin_value;
	logic [CW-1:0] fin_probes;
	logic          out_load;
	logic          match;
	logic          free;
	logic          last;
	logic [CW-1:0] cnt_inc;
	logic [SW:0]   idx_sum;
	logic [SW:0]   step_sum;
	logic [SW-1:0] idx_nxt;
	logic [SW-1:0] step_nxt;

	always_comb begin
		match   = rd_q.used && !rd_q.deleted && rd_q.klen == cur_q.key_length
			&& rd_q.key == cur_q.key[KW-1:0];
		free    = !rd_q.used || rd_q.deleted;
		cnt_inc = cnt_q + CW'(1);
		last    = (cnt_inc == CW'(TABLE_SLOTS));
		// next probe offset grows by 2i+2
		idx_sum  = {1'b0, idx_q} + {1'b0, step_q};
		idx_nxt  = (idx_sum >= (SW+1)'(TABLE_SLOTS)) ?
			SW'(idx_sum - (SW+1)'(TABLE_SLOTS)) : idx_sum[SW-1:0];
		step_sum = {1'b0, step_q} + (SW+1)'(2);
		step_nxt = (step_sum >= (SW+1)'(TABLE_SLOTS)) ?
			SW'(step_sum - (SW+1)'(TABLE_SLOTS)) : step_sum[SW-1:0];
	end

	always_comb begin
		state_d    = state_q;
		job_pop    = 1'b0;
		we         = 1'b0;
		waddr      = idx_q;
		wdata      = rd_q;
		re         = 1'b0;
		load       = 1'b0;
		adv        = 1'b0;
		fin        = 1'b0;
		fin_status = ST_NOT_FOUND;
		fin_value  = '0;
		fin_probes = '0;
		out_load   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == SW'(TABLE_SLOTS - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					load    = 1'b1;
					if (job.command == CMD_INSERT || job.command == CMD_SEARCH
						|| job.command == CMD_REMOVE) begin
						state_d = S_READ;
					end else begin
						fin     = 1'b1;
						state_d = S_DONE;
					end
				end
			end
			S_READ: begin
				re      = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				unique case (cur_q.command)
					CMD_INSERT: begin
						if (free) begin
							we          = 1'b1;
							wdata.used    = 1'b1;
							wdata.deleted = 1'b0;
							wdata.klen    = cur_q.key_length;
							wdata.key     = cur_q.key[KW-1:0];
							wdata.value   = cur_q.entry_value;
							fin         = 1'b1;
							fin_status  = ST_ADDED;
						end else if (match) begin
							fin        = 1'b1;
							fin_status = ST_EXISTS;
						end else if (last) begin
							fin        = 1'b1;
							fin_status = ST_FULL;
						end else begin
							adv = 1'b1;
						end
					end
					CMD_SEARCH: begin
						fin_probes = cnt_inc;
						if (!rd_q.used || last) begin
							fin = 1'b1;
						end else if (match) begin
							fin        = 1'b1;
							fin_status = ST_FOUND;
							fin_value  = rd_q.value;
						end else begin
							adv = 1'b1;
						end
						// a match on the final probe still counts as found
						if (rd_q.used && match) begin
							fin_status = ST_FOUND;
							fin_value  = rd_q.value;
						end
					end
					CMD_REMOVE: begin
						if (rd_q.used && match) begin
							we            = 1'b1;
							wdata.deleted = 1'b1;
							fin           = 1'b1;
							fin_status    = ST_REMOVED;
						end else if (!rd_q.used || last) begin
							fin = 1'b1;
						end else begin
							adv = 1'b1;
						end
					end
					default: fin = 1'b1;
				endcase
				state_d = fin ? S_DONE : S_READ;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + SW'(1);
			if (out_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q  <= job;
			idx_q  <= job.base[SW-1:0];
			step_q <= SW'(STEP0);
			cnt_q  <= '0;
		end else if (adv) begin
			idx_q  <= idx_nxt;
			step_q <= step_nxt;
			cnt_q  <= cnt_inc;
		end
		if (fin) begin
			res_status_q <= fin_status;
			res_value_q  <= fin_value;
			res_probes_q <= fin_probes;
		end
		if (out_load) begin
			rsp_q.status      <= res_status_q;
			rsp_q.found_value <= res_value_q;
			rsp_q.probe_count <= 7'(res_probes_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rd_q <= mem[idx_q];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ===== rtl/core/hash_table_quadratic_probe_top.sv =====
// top level of the quadratic-probe open-addressing hash table
//
//  channel | direction | handshake        | word
//  req     | in        | req_valid/stall  | command, key_bytes, key_length, entry_value
//  rsp     | out       | rsp_valid/stall  | status, found_value, probe_count
//
// front hashes one key character a cycle and takes no new word until the last one is in the queue
// back walks each probe as S_READ (registered read of the single-port slot memory),
// then S_EVAL (evaluate and optional write); S_IDLE loads a job, S_DONE reports it
// after reset the back sweeps all TABLE_SLOTS entries
// before it takes its first request; the front already accepts into the queue
// a stalled response holds in its register; a two-word queue lets the front
// keep hashing while the back walks probes
`default_nettype none
module hash_table_quadratic_probe_top #(
	parameter int TABLE_SLOTS = 101,
	parameter int KEY_CHARS   = 6
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  hqp_pkg::req_word_t  req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output hqp_pkg::rsp_word_t  rsp
);
	import hqp_pkg::*;

	// front to queue
	logic job_in_valid;
	logic job_full;
	job_t job_in;
	// queue to back
	logic job_out_valid;
	logic job_pop;
	job_t job_out;

	hqp_front #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.KEY_CHARS  (KEY_CHARS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.job_valid(job_in_valid),
		.job_full (job_full),
		.job      (job_in)
	);

	hqp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(job_in_valid),
		.full      (job_full),
		.push_job  (job_in),
		.pop_valid (job_out_valid),
		.pop       (job_pop),
		.pop_job   (job_out)
	);

	// probe engine and result register
	hqp_back #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.KEY_CHARS  (KEY_CHARS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_out_valid),
		.job_pop  (job_pop),
		.job      (job_out),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

// ===== rtl/core/hqp_checker.sv =====
// port-level checks for the hash table, bound to the top level
`default_nettype none
module hqp_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                rsp_valid,
	input wire                rsp_stall,
	input hqp_pkg::rsp_word_t rsp
);
	import hqp_pkg::*;

	// stalled response stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("response word changed while stalled");

	// only a found search carries a value
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_FOUND |-> rsp.found_value == '0)
		else $error("value on a response that is not found");

	// inserts and successful removes never report a probe count
	a_probe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_ADDED || rsp.status == ST_EXISTS
			|| rsp.status == ST_FULL || rsp.status == ST_REMOVED)
		|-> rsp.probe_count == 7'd0)
		else $error("probe count on a non-search response");

endmodule

bind hash_table_quadratic_probe_top hqp_checker u_hqp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the quadratic-probe hash table: scoreboard, drivers and checks
`timescale 1ns / 1ps
module tb;
	import hqp_pkg::*;

	localparam int SLOTS = 101;
	localparam int CHARS = 6;
	localparam int N_RANDOM = 310;
	localparam longint CYCLE_LIMIT = 2000000;

	// table model and queue of expected responses
	class probe_table_sb;
		logic [47:0] keys [SLOTS];
		logic [2:0] lens [SLOTS];
		logic [VALUE_W-1:0] vals [SLOTS];
		bit used [SLOTS];
		bit gone [SLOTS];
		rsp_word_t pending [$];
		int errors;

		function new();
			errors = 0;
			for (int s = 0; s < SLOTS; s++) begin
				used[s] = 0;
				gone[s] = 0;
				keys[s] = '0;
				lens[s] = '0;
				vals[s] = '0;
			end
		endfunction

		function void note_request(req_word_t w);
			int n, h, base, idx;
			logic [47:0] k;
			rsp_word_t r;
			n = (w.key_length > CHARS) ? CHARS : w.key_length;
			k = '0;
			h = 0;
			for (int c = 0; c < n; c++) begin
				k[47-8*c -: 8] = w.key_bytes[47-8*c -: 8];
				h = (h * 31 + w.key_bytes[47-8*c -: 8]) % SLOTS;
			end
			base = h;
			r.status = ST_NOT_FOUND;
			r.found_value = '0;
			r.probe_count = '0;
			if (w.command == CMD_INSERT) begin
				r.status = ST_FULL;
				for (int i = 0; i < SLOTS; i++) begin
					idx = (base + (i + i * i) % SLOTS) % SLOTS;
					if (!used[idx] || gone[idx]) begin
						keys[idx] = k;
						lens[idx] = 3'(n);
						vals[idx] = w.entry_value;
						used[idx] = 1;
						gone[idx] = 0;
						r.status = ST_ADDED;
						break;
					end
					if (lens[idx] == n && keys[idx] == k) begin
						r.status = ST_EXISTS;
						break;
					end
				end
			end else if (w.command == CMD_SEARCH || w.command == CMD_REMOVE) begin
				for (int i = 0; i < SLOTS; i++) begin
					idx = (base + (i + i * i) % SLOTS) % SLOTS;
					if (w.command == CMD_SEARCH)
						r.probe_count++;
					if (!used[idx])
						break;
					if (!gone[idx] && lens[idx] == n && keys[idx] == k) begin
						if (w.command == CMD_SEARCH) begin
							r.status = ST_FOUND;
							r.found_value = vals[idx];
						end else begin
							gone[idx] = 1;
							r.status = ST_REMOVED;
						end
						break;
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void check_response(rsp_word_t got);
			rsp_word_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %p", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.found_value !== want.found_value) begin
				$display("%0t: found_value expected %0d actual %0d", $time,
					want.found_value, got.found_value);
				errors++;
			end
			if (got.probe_count !== want.probe_count) begin
				$display("%0t: probe_count expected %0d actual %0d", $time,
					want.probe_count, got.probe_count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_word_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_word_t rsp;

	probe_table_sb sb;
	longint cycles = 0;
	bit hold_off; // long receiver stall request
	bit hold_done;
	logic [47:0] pool [16]; // small key set so words hit each other often
	logic [2:0] pool_len [16];

	hash_table_quadratic_probe_top #(.TABLE_SLOTS(SLOTS), .KEY_CHARS(CHARS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// short gaps mostly, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one word and wait for it to be taken
	task automatic send_word(req_word_t w);
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(w);
	endtask

	task automatic idle_sender(int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic req_word_t make_word(logic [1:0] cmd, logic [47:0] k, logic [2:0] n,
		logic [VALUE_W-1:0] v);
		req_word_t w;
		w.command = cmd;
		w.key_bytes = k;
		w.key_length = n;
		w.entry_value = v;
		return w;
	endfunction

	function automatic logic [VALUE_W-1:0] rand_value();
		logic [VALUE_W-1:0] v;
		v = VALUE_W'({$urandom(), $urandom()});
		if ($urandom_range(0, 3) == 0)
			v = (v[0]) ? '1 : '0;
		return v;
	endfunction

	// random key, junk left in bytes beyond the length on purpose
	function automatic logic [47:0] rand_key();
		logic [47:0] k;
		k = 48'({$urandom(), $urandom()});
		return k;
	endfunction

	// receiver: random stalls, one long hold-off on request, check every word
	initial begin
		int g;
		rsp_stall <= 1'b0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
			if (hold_off && !hold_done) begin
				rsp_stall <= 1'b1;
				g = 0;
				while (g < 400) begin
					@(posedge clk);
					g++;
				end
				hold_done = 1;
				rsp_stall <= 1'b0;
			end else begin
				g = gap_len();
				if (g != 0 && $urandom_range(0, 1)) begin
					rsp_stall <= 1'b1;
					repeat (g) @(posedge clk);
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		req_word_t w;
		int wait_cnt;
		logic [47:0] fk;
		sb = new();
		hold_off = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		for (int p = 0; p < 16; p++) begin
			pool[p] = rand_key();
			pool_len[p] = 3'($urandom_range(0, 7));
		end
		// a pair of keys equal apart from bytes past the length
		pool[1] = pool[0] ^ 48'h0000_0000_00ff;
		pool_len[0] = 3'd4;
		pool_len[1] = 3'd4;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words: empty key, overlong length, extreme values, every command
		send_word(make_word(CMD_SEARCH, 48'h0, 3'd0, '0));
		send_word(make_word(CMD_INSERT, 48'h0, 3'd0, '1));
		send_word(make_word(CMD_INSERT, 48'hffff_ffff_ffff, 3'd0, '0));
		send_word(make_word(CMD_SEARCH, 48'h1234_5678_9abc, 3'd0, '0));
		send_word(make_word(CMD_INSERT, 48'hffff_ffff_ffff, 3'd7, 34'h2_5555_5555));
		send_word(make_word(CMD_SEARCH, 48'hffff_ffff_ffff, 3'd6, '0));
		send_word(make_word(CMD_INSERT, pool[0], 3'd4, 34'd7));
		send_word(make_word(CMD_INSERT, pool[1], 3'd4, 34'd8));
		send_word(make_word(CMD_SEARCH, pool[1], 3'd4, '1));
		send_word(make_word(CMD_REMOVE, pool[0], 3'd4, '0));
		send_word(make_word(CMD_REMOVE, pool[0], 3'd4, '0));
		send_word(make_word(CMD_SEARCH, pool[0], 3'd4, '0));
		send_word(make_word(CMD_INSERT, pool[0], 3'd4, 34'd9));
		send_word(make_word(CMD_SEARCH, pool[0], 3'd4, '0));
		send_word(make_word(2'd3, 48'h8080_8080_8080, 3'd6, '1));
		send_word(make_word(CMD_INSERT, 48'h8000_0000_0001, 3'd1, 34'd1));
		send_word(make_word(CMD_REMOVE, 48'h8000_0000_0001, 3'd1, 34'd1));

		// pressure: hold the response side while words keep coming
		hold_off = 1;
		for (int i = 0; i < 12; i++)
			send_word(make_word(CMD_SEARCH, pool[i], pool_len[i], '0));

		// insert more distinct keys than there are slots so probe walks run long
		for (int i = 0; i < 110; i++) begin
			fk = rand_key();
			send_word(make_word(CMD_INSERT, {fk[47:8], 8'(i)}, 3'd6, rand_value()));
		end

		// random words, mostly on the small key pool
		for (int i = 0; i < N_RANDOM; i++) begin
			int r, p;
			logic [1:0] cmd;
			r = $urandom_range(0, 99);
			p = $urandom_range(0, 15);
			cmd = (r < 35) ? CMD_INSERT : (r < 70) ? CMD_SEARCH : (r < 95) ? CMD_REMOVE : 2'd3;
			if ($urandom_range(0, 4) == 0)
				w = make_word(cmd, rand_key(), 3'($urandom_range(0, 7)), rand_value());
			else
				w = make_word(cmd, pool[p] ^ ($urandom_range(0, 1) ? 48'h0 : 48'h1),
					pool_len[p], rand_value());
			send_word(w);
			if ($urandom_range(0, 2) == 0)
				idle_sender(gap_len());
		end
		req_valid <= 1'b0;

		// drain, then idle quietly before the verdict
		wait_cnt = 0;
		while (sb.pending.size() != 0 && wait_cnt < 500000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/hqp_pkg.sv
rtl/core/hqp_front.sv
rtl/core/hqp_queue.sv
rtl/core/hqp_back.sv
rtl/core/hash_table_quadratic_probe_top.sv
rtl/core/hqp_checker.sv
tb/tb.sv
